### rtl/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, constants and helpers for the ring log directory manager.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    localparam int DIR_SLOTS   = 15;
    localparam int BLOCK_BYTES = 512;
    localparam int NAME_BYTES  = 8;

    localparam int NAME_W   = 64;
    localparam int SIZE_W   = 24;
    localparam int SLOT_W   = 16;
    localparam int BLOCK_W  = 32;
    localparam int IDX_W    = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int CNT_W    = $clog2(DIR_SLOTS + 1);
    localparam int BLK_SH   = $clog2(BLOCK_BYTES);
    localparam int BLK_W    = SIZE_W + 1 - BLK_SH;
    localparam int STRIDE_W = BLK_W + 1;
    localparam int PROD_W   = STRIDE_W + SLOT_W;

    localparam logic [2:0] OP_FORMAT = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_LOCATE = 3'd4;
    localparam logic [2:0] OP_COUNT  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_TBL_FULL  = 3'd3;
    localparam logic [2:0] ST_NO_SPACE  = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_BAD_INDEX = 3'd7;

    typedef struct packed {
        logic [2:0]        operation;
        logic [NAME_W-1:0] dir_name;
        logic [3:0]        name_length;
        logic [SLOT_W-1:0] max_files;
        logic [SIZE_W-1:0] max_file_size;
        logic [SIZE_W-1:0] file_size;
        logic [SLOT_W-1:0] file_index;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [BLOCK_W-1:0] header_block;
        logic [15:0]        data_blocks;
        logic [15:0]        file_count;
        logic               overwrote_oldest;
    } rsp_item_t;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [SLOT_W-1:0]  slots;
        logic [SIZE_W-1:0]  size_limit;
        logic [BLOCK_W-1:0] base_block;
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
        logic               full;
    } entry_t;

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // case-insensitive prefix compare over the first len bytes
    function automatic logic name_match(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b,
                                        input logic [3:0] len);
        logic [3:0] eff;
        logic       same;
        eff  = (len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : len;
        same = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (4'(i) < eff && fold(a[8*i +: 8]) != fold(b[8*i +: 8]))
                same = 1'b0;
        end
        return same;
    endfunction

    function automatic logic [BLK_W-1:0] blocks_for(input logic [SIZE_W-1:0] bytes);
        logic [SIZE_W:0] sum;
        sum = {1'b0, bytes} + (SIZE_W+1)'(BLOCK_BYTES - 1);
        return BLK_W'(sum >> BLK_SH);
    endfunction

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v,
                                                   input logic [SLOT_W-1:0] slots);
        logic [SLOT_W:0] nxt;
        nxt = {1'b0, v} + (SLOT_W+1)'(1);
        if (slots == '0 || nxt == {1'b0, slots})
            return '0;
        return nxt[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] files_of(input logic [SLOT_W-1:0] slots,
                                                   input logic [SLOT_W-1:0] head,
                                                   input logic [SLOT_W-1:0] tail,
                                                   input logic full);
        if (full)
            return slots;
        if (head >= tail)
            return head - tail;
        return slots + head - tail;
    endfunction

endpackage

`default_nettype wire

### rtl/rld_if.sv
// ----------------------------------------------------------------------------
// rld_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_req_if;
    logic              valid;
    logic              ready;
    rld_pkg::req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rld_rsp_if;
    logic              valid;
    logic              ready;
    rld_pkg::rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ring_log_directory_manager.sv
// Search: the name search reads one table entry per cycle from the entry RAM.
// Throughput: one request at a time; the next is taken once the current one
//   has posted its response, which may still wait in the output register.
// Reset: clears the directory count and total_blocks, sets the allocation
//   pointer to 1; entries are undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// ring_log_directory_manager
// Directory table of ring-buffer log directories on a block device.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_log_directory_manager (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rld_req_if.sink               req,
    rld_rsp_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [31:0]      cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    localparam int IDX_W    = rld_pkg::IDX_W;
    localparam int CNT_W    = rld_pkg::CNT_W;
    localparam int SLOT_W   = rld_pkg::SLOT_W;
    localparam int BLOCK_W  = rld_pkg::BLOCK_W;
    localparam int STRIDE_W = rld_pkg::STRIDE_W;
    localparam int PROD_W   = rld_pkg::PROD_W;

    state_t                  state_reg;
    rld_pkg::req_item_t      item_reg;
    logic [31:0]             total_reg;
    logic [CNT_W-1:0]        dir_count_reg;
    logic [BLOCK_W-1:0]      next_free_reg;
    logic [CNT_W-1:0]        scan_addr_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    rld_pkg::entry_t         ent_reg;
    rld_pkg::entry_t         rd_data_reg;
    logic [2:0]              st_reg;
    logic [SLOT_W-1:0]       files_reg;
    logic [STRIDE_W-1:0]     mul_a_reg;
    logic [SLOT_W-1:0]       mul_b_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_valid_reg;
    rld_pkg::rsp_item_t      out_reg;

    rld_pkg::entry_t         mem [rld_pkg::DIR_SLOTS];

    logic                    accept;
    logic                    out_free;
    logic                    match;
    logic [SLOT_W-1:0]       files_cur;
    logic [2:0]              st_next;
    logic [STRIDE_W-1:0]     mul_a_next;
    logic [SLOT_W-1:0]       mul_b_next;
    logic [SLOT_W:0]         loc_sum;
    logic                    mem_we;
    logic [IDX_W-1:0]        wr_idx;
    rld_pkg::entry_t         wr_data;
    rld_pkg::rsp_item_t      rsp_next;
    logic                    add_commit;
    logic [BLOCK_W:0]        add_end;
    logic [SLOT_W-1:0]       n_head;
    logic [SLOT_W-1:0]       n_tail;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign match = rld_pkg::name_match(item_reg.dir_name, rd_data_reg.name,
                                       item_reg.name_length);

    // entry RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_idx] <= wr_data;
        rd_data_reg <= mem[scan_addr_reg[IDX_W-1:0]];
    end

    // status checks and multiplier operands
    always_comb
    begin
        files_cur  = rld_pkg::files_of(ent_reg.slots, ent_reg.head, ent_reg.tail,
                                       ent_reg.full);
        loc_sum    = {1'b0, item_reg.file_index} + {1'b0, ent_reg.tail};
        mul_a_next = STRIDE_W'(rld_pkg::blocks_for(ent_reg.size_limit)) + STRIDE_W'(1);
        mul_b_next = ent_reg.head;
        st_next    = rld_pkg::ST_OK;
        case (item_reg.operation)
            rld_pkg::OP_FORMAT: st_next = rld_pkg::ST_OK;
            rld_pkg::OP_ADD:
            begin
                mul_a_next = STRIDE_W'(rld_pkg::blocks_for(item_reg.max_file_size))
                             + STRIDE_W'(1);
                mul_b_next = item_reg.max_files;
                if (hit_reg)
                    st_next = rld_pkg::ST_EXISTS;
                else if (dir_count_reg >= CNT_W'(rld_pkg::DIR_SLOTS))
                    st_next = rld_pkg::ST_TBL_FULL;
                else if (item_reg.max_files == '0)
                    st_next = rld_pkg::ST_NO_SPACE;
            end
            rld_pkg::OP_WRITE:
            begin
                if (!hit_reg)
                    st_next = rld_pkg::ST_NOT_FOUND;
                else if (item_reg.file_size > ent_reg.size_limit)
                    st_next = rld_pkg::ST_TOO_LARGE;
            end
            rld_pkg::OP_DELETE:
            begin
                if (!hit_reg)
                    st_next = rld_pkg::ST_NOT_FOUND;
                else if (files_cur == '0)
                    st_next = rld_pkg::ST_EMPTY;
            end
            rld_pkg::OP_LOCATE:
            begin
                // index < count <= slots and tail < slots: one subtract wraps it
                mul_b_next = (loc_sum >= {1'b0, ent_reg.slots})
                             ? SLOT_W'(loc_sum - {1'b0, ent_reg.slots})
                             : loc_sum[SLOT_W-1:0];
                if (!hit_reg)
                    st_next = rld_pkg::ST_NOT_FOUND;
                else if (files_cur == '0)
                    st_next = rld_pkg::ST_EMPTY;
                else if (item_reg.file_index >= files_cur)
                    st_next = rld_pkg::ST_BAD_INDEX;
            end
            rld_pkg::OP_COUNT:
            begin
                if (!hit_reg)
                    st_next = rld_pkg::ST_NOT_FOUND;
            end
            default: st_next = rld_pkg::ST_BAD_INDEX;
        endcase
    end

    // final update: response, write-back, table pointers
    always_comb
    begin
        rsp_next   = '0;
        rsp_next.status = st_reg;
        mem_we     = 1'b0;
        wr_idx     = hit_idx_reg;
        wr_data    = ent_reg;
        add_commit = 1'b0;
        add_end    = {1'b0, next_free_reg} + (BLOCK_W+1)'(prod_reg);
        n_head     = rld_pkg::wrap_inc(ent_reg.head, ent_reg.slots);
        n_tail     = ent_reg.full ? rld_pkg::wrap_inc(ent_reg.tail, ent_reg.slots)
                                  : ent_reg.tail;
        case (item_reg.operation)
            rld_pkg::OP_ADD:
            begin
                if (st_reg == rld_pkg::ST_OK)
                begin
                    if (add_end > {1'b0, total_reg})
                        rsp_next.status = rld_pkg::ST_NO_SPACE;
                    else
                    begin
                        add_commit         = 1'b1;
                        mem_we             = 1'b1;
                        wr_idx             = dir_count_reg[IDX_W-1:0];
                        wr_data.name       = item_reg.dir_name;
                        wr_data.slots      = item_reg.max_files;
                        wr_data.size_limit = item_reg.max_file_size;
                        wr_data.base_block = next_free_reg;
                        wr_data.head       = '0;
                        wr_data.tail       = '0;
                        wr_data.full       = 1'b0;
                    end
                end
            end
            rld_pkg::OP_WRITE:
            begin
                if (hit_reg)
                    rsp_next.file_count = files_reg;
                if (st_reg == rld_pkg::ST_OK)
                begin
                    mem_we       = 1'b1;
                    wr_data.head = n_head;
                    wr_data.tail = n_tail;
                    wr_data.full = (n_head == n_tail);
                    rsp_next.header_block = ent_reg.base_block + BLOCK_W'(prod_reg);
                    rsp_next.data_blocks  = 16'(rld_pkg::blocks_for(item_reg.file_size));
                    rsp_next.overwrote_oldest = ent_reg.full;
                    rsp_next.file_count = rld_pkg::files_of(ent_reg.slots, n_head,
                                                            n_tail, n_head == n_tail);
                end
            end
            rld_pkg::OP_DELETE:
            begin
                if (st_reg == rld_pkg::ST_OK)
                begin
                    mem_we       = 1'b1;
                    wr_data.full = 1'b0;
                    wr_data.tail = rld_pkg::wrap_inc(ent_reg.tail, ent_reg.slots);
                    rsp_next.file_count = rld_pkg::files_of(ent_reg.slots, ent_reg.head,
                                                            wr_data.tail, 1'b0);
                end
            end
            rld_pkg::OP_LOCATE:
            begin
                if (hit_reg)
                    rsp_next.file_count = files_reg;
                if (st_reg == rld_pkg::ST_OK)
                    rsp_next.header_block = ent_reg.base_block + BLOCK_W'(prod_reg);
            end
            rld_pkg::OP_COUNT:
            begin
                if (hit_reg)
                    rsp_next.file_count = files_reg;
            end
            default: ;
        endcase
        if (state_reg != S_FIN || !out_free)
            mem_we = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            total_reg     <= '0;
            dir_count_reg <= '0;
            next_free_reg <= BLOCK_W'(1);
            scan_addr_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            ent_reg       <= '0;
            st_reg        <= rld_pkg::ST_OK;
            files_reg     <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_wdata;
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg      <= req.data;
                        hit_reg       <= 1'b0;
                        scan_addr_reg <= '0;
                        cmp_vld_reg   <= 1'b0;
                        if (req.data.operation >= rld_pkg::OP_ADD &&
                            req.data.operation <= rld_pkg::OP_COUNT)
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_EXEC;
                    end
                end
                S_SCAN:
                begin
                    // read of entry n overlaps compare of entry n-1
                    if (cmp_vld_reg && match)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                        ent_reg     <= rd_data_reg;
                        state_reg   <= S_EXEC;
                    end
                    else if (!cmp_vld_reg && scan_addr_reg >= dir_count_reg)
                        state_reg <= S_EXEC;
                    if (scan_addr_reg < dir_count_reg)
                    begin
                        cmp_vld_reg   <= 1'b1;
                        cmp_idx_reg   <= scan_addr_reg[IDX_W-1:0];
                        scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                    end
                    else
                        cmp_vld_reg <= 1'b0;
                end
                S_EXEC:
                begin
                    st_reg    <= st_next;
                    files_reg <= files_cur;
                    mul_a_reg <= mul_a_next;
                    mul_b_reg <= mul_b_next;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(mul_a_reg) * PROD_W'(mul_b_reg);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_reg       <= rsp_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (item_reg.operation == rld_pkg::OP_FORMAT)
                        begin
                            dir_count_reg <= '0;
                            next_free_reg <= BLOCK_W'(1);
                        end
                        else if (add_commit)
                        begin
                            dir_count_reg <= dir_count_reg + CNT_W'(1);
                            next_free_reg <= add_end[BLOCK_W-1:0];
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/rld_checker.sv
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks of the ring log directory manager, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [31:0] rsp_header_block,
    input wire logic [15:0] rsp_data_blocks,
    input wire logic        rsp_overwrote
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("response dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in flight");

    a_over_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_overwrote |-> rsp_status == rld_pkg::ST_OK)
        else $error("overwrite flagged on failed write");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != rld_pkg::ST_OK
        |-> rsp_header_block == '0 && rsp_data_blocks == '0)
        else $error("failed transaction carries block data");

endmodule

bind ring_log_directory_manager rld_checker u_rld_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.data.status),
    .rsp_header_block (rsp.data.header_block),
    .rsp_data_blocks  (rsp.data.data_blocks),
    .rsp_overwrote    (rsp.data.overwrote_oldest)
);

`default_nettype wire
